FILE: hw/rtl/kbv_pkg.sv
// Shared constants and widths for the knapsack best-value core.
package kbv_pkg;

	localparam int MAX_CAPACITY_DEF = 1023;
	localparam int CAP_W            = 10;
	localparam int WEIGHT_W         = 10;
	localparam int VALUE_W          = 16;
	localparam int BEST_W           = 32;
	localparam int S_TDATA_W        = 32;
	localparam int M_TDATA_W        = 32;
	localparam int PADDR_W          = 3;
	localparam int PDATA_W          = 32;

	localparam logic REG_CAPACITY = 1'b0;

endpackage

FILE: hw/rtl/kbv_table.sv
// Best-value table: one write port, two registered read ports.
module kbv_table #(
	parameter int DEPTH = kbv_pkg::MAX_CAPACITY_DEF + 1,
	parameter int AW    = $clog2(kbv_pkg::MAX_CAPACITY_DEF + 1)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [kbv_pkg::BEST_W-1:0] wr_data,
	input  logic [AW-1:0]             rd_addr_a,
	input  logic [AW-1:0]             rd_addr_b,
	output logic [kbv_pkg::BEST_W-1:0] rd_data_a,
	output logic [kbv_pkg::BEST_W-1:0] rd_data_b
);

	logic [kbv_pkg::BEST_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

FILE: hw/rtl/kbv_alu.sv
// Saturating add of item value to a base entry and compare with the current entry.
module kbv_alu (
	input  logic [kbv_pkg::BEST_W-1:0]  cur,
	input  logic [kbv_pkg::BEST_W-1:0]  base,
	input  logic [kbv_pkg::VALUE_W-1:0] value,
	output logic                        upd,
	output logic [kbv_pkg::BEST_W-1:0]  cand
);

	logic [kbv_pkg::BEST_W:0] sum;

	always_comb begin
		sum  = {1'b0, base} + (kbv_pkg::BEST_W + 1)'(value);
		cand = sum[kbv_pkg::BEST_W] ? {kbv_pkg::BEST_W{1'b1}} : sum[kbv_pkg::BEST_W-1:0];
		upd  = cand > cur;
	end

endmodule

FILE: hw/rtl/knapsack_best_value_core.sv
// Top level: control sequencer, config register and stream ports of the knapsack core.
// Per object of weight w: the table sweep runs from cap down to max(w,1), then a drain state, one entry
//   per cycle through the table's read-modify-write loop; cap = min(capacity, MAX_CAPACITY).
// After the last object the result is read out through the RES and EMIT states that follow the sweep.
// Each set is followed by a clear pass over all MAX_CAPACITY+1 entries; input is held off meanwhile.
// Reset clears control state and runs the same clear pass.
module knapsack_best_value_core #(
	parameter int MAX_CAPACITY = kbv_pkg::MAX_CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [kbv_pkg::S_TDATA_W-1:0]  s_tdata,  // item_weight[9:0], item_value[25:10]
	input  logic                           s_tlast,  // last_item
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [kbv_pkg::M_TDATA_W-1:0]  m_tdata,  // best_value[31:0]
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [kbv_pkg::PADDR_W-1:0]    paddr,
	input  logic [kbv_pkg::PDATA_W-1:0]    pwdata,
	output logic [kbv_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);

	localparam int DEPTH = MAX_CAPACITY + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int MW    = (AW > kbv_pkg::CAP_W) ? AW : kbv_pkg::CAP_W;
	localparam logic [MW-1:0] MAXC = MW'(MAX_CAPACITY);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CAPACITY);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_RES   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]                    state_q;
	logic [kbv_pkg::CAP_W-1:0]     capacity_q;
	logic [AW-1:0]                 clr_q;
	logic [AW-1:0]                 j_q;
	logic [AW-1:0]                 lo_q;
	logic [AW-1:0]                 w_q;
	logic [kbv_pkg::VALUE_W-1:0]   v_q;
	logic                          last_q;
	logic                          valid_s1;
	logic [AW-1:0]                 addr_s1;
	logic                          m_tvalid_q;
	logic [kbv_pkg::BEST_W-1:0]    best_q;

	logic [MW-1:0]                 cap_ext;
	logic [AW-1:0]                 cap_use;
	logic [kbv_pkg::WEIGHT_W-1:0]  in_w;
	logic [kbv_pkg::VALUE_W-1:0]   in_v;
	logic [MW-1:0]                 in_w_ext;
	logic                          skip;
	logic                          accept;

	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [kbv_pkg::BEST_W-1:0]    wr_data;
	logic [AW-1:0]                 rd_addr_a;
	logic [AW-1:0]                 rd_addr_b;
	logic [kbv_pkg::BEST_W-1:0]    rd_data_a;
	logic [kbv_pkg::BEST_W-1:0]    rd_data_b;
	logic                          alu_upd;
	logic [kbv_pkg::BEST_W-1:0]    alu_cand;

	// config port
	assign pready = 1'b1;
	assign prdata = kbv_pkg::PDATA_W'(capacity_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == kbv_pkg::REG_CAPACITY) begin
			capacity_q <= pwdata[kbv_pkg::CAP_W-1:0];
		end
	end

	// effective capacity and input decode
	always_comb begin
		cap_ext  = MW'(capacity_q);
		cap_use  = (cap_ext > MAXC) ? AW'(MAXC) : AW'(cap_ext);
		in_w     = s_tdata[kbv_pkg::WEIGHT_W-1:0];
		in_v     = s_tdata[kbv_pkg::WEIGHT_W +: kbv_pkg::VALUE_W];
		in_w_ext = MW'(in_w);
		skip     = (in_w_ext > MW'(cap_use)) || (cap_use == '0);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			j_q        <= '0;
			lo_q       <= '0;
			w_q        <= '0;
			last_q     <= 1'b0;
			valid_s1   <= 1'b0;
			addr_s1    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_RUN);
			addr_s1  <= j_q;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == LAST_ADDR) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						last_q <= s_tlast;
						if (skip) begin
							state_q <= s_tlast ? ST_RES : ST_IDLE;
						end else begin
							w_q     <= AW'(in_w);
							lo_q    <= (in_w == '0) ? AW'(1) : AW'(in_w);
							j_q     <= cap_use;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					j_q <= j_q - 1'b1;
					if (j_q == lo_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= last_q ? ST_RES : ST_IDLE;
				end
				ST_RES: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!m_tvalid_q) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_CLEAR;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q <= in_v;
		end
		if (state_q == ST_EMIT && !m_tvalid_q) begin
			best_q <= rd_data_a;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = kbv_pkg::M_TDATA_W'(best_q);

	// table access
	always_comb begin
		rd_addr_a = (state_q == ST_RES || state_q == ST_EMIT) ? cap_use : j_q;
		rd_addr_b = j_q - w_q;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = valid_s1 && alu_upd;
			wr_addr = addr_s1;
			wr_data = alu_cand;
		end
	end

	kbv_table #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	kbv_alu u_alu (
		.cur  (rd_data_a),
		.base (rd_data_b),
		.value(v_q),
		.upd  (alu_upd),
		.cand (alu_cand)
	);

	// entry zero is never written outside the clear pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q != ST_CLEAR) |-> (wr_addr != '0))
		else $error("write to entry zero during update");

	// pending write always lies above the entries being read
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && valid_s1) |-> (addr_s1 > j_q))
		else $error("read overlaps pending write");

	// sweep stays within its bounds
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (j_q >= lo_q && j_q >= w_q))
		else $error("sweep index below lower bound");

	// no update writes are in flight while clearing or taking input
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR || state_q == ST_IDLE) |-> !valid_s1)
		else $error("update in flight outside sweep");

endmodule
